/* design/stg_pkg.sv */
// Package for the sinusoid trajectory generator.
// Holds the CORDIC arctangent table, fixed constants and shared types.
package stg_pkg;

    localparam int TBL_LEN = 24;
    localparam logic [31:0] GAIN_Q30  = 32'h26DD3B6A;
    localparam logic [31:0] TWOPI_Q29 = 32'hC90FDAA2;

    localparam logic [1:0] REG_OFFSET    = 2'd0;
    localparam logic [1:0] REG_AMPLITUDE = 2'd1;
    localparam logic [1:0] REG_FREQUENCY = 2'd2;
    localparam logic [1:0] REG_PHASE     = 2'd3;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turns(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:  r = 32'h20000000;
                5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B;
                5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;
                5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;
                5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;
                5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA;
                5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;
                5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C;
                5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3;
                5'd23: r = 32'h00000051;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

    // per-item values carried alongside the CORDIC
    typedef struct packed {
        logic signed [31:0] off;
        logic signed [31:0] amp;
        logic        [23:0] freq;
        logic               neg;
    } side_t;

    // CORDIC stage state
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } rot_t;

endpackage

/* design/stg_cordic.sv */
// Pipelined rotation-mode CORDIC, one register stage per iteration.
// Depends on stg_pkg for the arctangent table and stage types.
module stg_cordic
    import stg_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [31:0] in_angle,
    input  side_t              in_side,
    output logic               out_valid,
    output logic signed [33:0] out_cos,
    output logic signed [33:0] out_sin,
    output side_t              out_side
);

    rot_t  rot_reg   [CORDIC_STAGES+1];
    side_t side_reg  [CORDIC_STAGES+1];
    logic  valid_reg [CORDIC_STAGES+1];

    // stage 0 input
    always_comb
    begin
        rot_reg[0]   = '{x: 34'(signed'(GAIN_Q30)), y: '0, z: 34'(in_angle)};
        side_reg[0]  = in_side;
        valid_reg[0] = in_valid;
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        rot_t rot_next;
        always_comb
        begin
            if (!rot_reg[i].z[33])
            begin
                rot_next.x = rot_reg[i].x - (rot_reg[i].y >>> i);
                rot_next.y = rot_reg[i].y + (rot_reg[i].x >>> i);
                rot_next.z = rot_reg[i].z - 34'(atan_turns(5'(i)));
            end
            else
            begin
                rot_next.x = rot_reg[i].x + (rot_reg[i].y >>> i);
                rot_next.y = rot_reg[i].y - (rot_reg[i].x >>> i);
                rot_next.z = rot_reg[i].z + 34'(atan_turns(5'(i)));
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i+1] <= 1'b0;
            else if (en)
                valid_reg[i+1] <= valid_reg[i];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rot_reg[i+1]  <= rot_next;
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = valid_reg[CORDIC_STAGES];
    assign out_cos   = rot_reg[CORDIC_STAGES].x;
    assign out_sin   = rot_reg[CORDIC_STAGES].y;
    assign out_side  = side_reg[CORDIC_STAGES];

endmodule

/* design/stg_scale.sv */
// Product pipeline: amplitude scaling, angular rate, derivatives, saturation.
// Depends on stg_pkg for constants and the side-data type.
module stg_scale
    import stg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [33:0] in_cos,
    input  logic signed [33:0] in_sin,
    input  side_t              in_side,
    output logic               out_valid,
    output logic        [47:0] out_pos,
    output logic        [47:0] out_vel,
    output logic        [47:0] out_acc
);

    localparam logic signed [63:0] OUT_MAX = 64'sh00007FFFFFFFFFFF;
    localparam logic signed [63:0] OUT_MIN = -64'sh0000800000000000;

    logic [4:0] v_reg;

    // stage 1: sign fix; stage 2: A*sin, A*cos, f*2pi
    logic signed [31:0] s1_sin_reg, s1_cos_reg;
    logic signed [31:0] off1_reg, amp1_reg;
    logic        [23:0] f1_reg;
    logic signed [31:0] sfix, cfix;
    assign sfix = in_side.neg ? -in_sin[31:0] : in_sin[31:0];
    assign cfix = in_side.neg ? -in_cos[31:0] : in_cos[31:0];

    logic signed [63:0] ps_reg, pc_reg;
    logic        [55:0] pw_reg;
    logic signed [31:0] off2_reg;

    // stage 3 (rounded values)
    logic signed [33:0] asin3_reg, acos3_reg;
    logic        [27:0] w3_reg;
    logic signed [31:0] off3_reg;

    // stage 4: w*acos, w*w
    logic signed [63:0] pv4_reg;
    logic        [55:0] ww4_reg;
    logic signed [33:0] asin4_reg;
    logic signed [31:0] off4_reg;

    // stage 5: h*asin, l*asin
    logic signed [63:0] vel5_reg, ph5_reg, pl5_reg;
    logic signed [33:0] asin5_reg;
    logic signed [31:0] off5_reg;

    logic signed [63:0] pos_n, acc_n;
    logic        [39:0] w2;
    assign w2 = 40'((ww4_reg + 56'd32768) >> 16);

    function automatic logic [47:0] sat48(input logic signed [63:0] v);
        begin
            if (v > OUT_MAX)
                return OUT_MAX[47:0];
            else if (v < OUT_MIN)
                return OUT_MIN[47:0];
            return v[47:0];
        end
    endfunction

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            v_reg     <= {v_reg[3:0], in_valid};
            out_valid <= v_reg[4];
        end
    end

    always_comb
    begin
        pos_n = 64'(off5_reg) + 64'(asin5_reg);
        acc_n = -(ph5_reg + ((pl5_reg + 64'sd32768) >>> 16));
    end

    // data pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_sin_reg <= sfix;
            s1_cos_reg <= cfix;
            off1_reg   <= in_side.off;
            amp1_reg   <= in_side.amp;
            f1_reg     <= in_side.freq;

            ps_reg   <= 64'(amp1_reg) * 64'(s1_sin_reg);
            pc_reg   <= 64'(amp1_reg) * 64'(s1_cos_reg);
            pw_reg   <= 56'(f1_reg) * 56'(TWOPI_Q29);
            off2_reg <= off1_reg;

            asin3_reg <= 34'((ps_reg + 64'sd536870912) >>> 30);
            acos3_reg <= 34'((pc_reg + 64'sd536870912) >>> 30);
            w3_reg    <= 28'((pw_reg + 56'd268435456) >> 29);
            off3_reg  <= off2_reg;

            pv4_reg   <= 64'(signed'({1'b0, w3_reg})) * 64'(acos3_reg);
            ww4_reg   <= 56'(w3_reg) * 56'(w3_reg);
            asin4_reg <= asin3_reg;
            off4_reg  <= off3_reg;

            vel5_reg  <= (pv4_reg + 64'sd32768) >>> 16;
            ph5_reg   <= 64'(signed'({1'b0, w2[39:16]})) * 64'(asin4_reg);
            pl5_reg   <= 64'(signed'({1'b0, w2[15:0]})) * 64'(asin4_reg);
            asin5_reg <= asin4_reg;
            off5_reg  <= off4_reg;

            out_pos <= sat48(pos_n);
            out_vel <= sat48(vel5_reg);
            out_acc <= sat48(acc_n);
        end
    end

endmodule

/* design/sinusoid_trajectory_generator.sv */
// Top level of the sinusoid trajectory generator.
// Uses stg_pkg, stg_cordic and stg_scale.
//
// Usage: each request on s_axis carries a time stamp (unsigned Q16.16 s).
// m_axis returns one result per request: position, velocity and
// acceleration, each signed Q32.16 and saturated.
// Registers (offset, amplitude, frequency, phase) are written through
// cfg_we/cfg_index/cfg_data; they reset to zero. The user must write them
// only while the block is idle; the block itself does not enforce this.
// Stages: 1 angle stage + CORDIC_STAGES rotation stages + 6 product and output stages.
// Throughput: one request per clock while the receiver does not stall; every stage is a register.
// The whole pipeline advances together when the output is free or taken;
// when the receiver stalls with a result held, the pipeline freezes and
// s_axis_tready falls, so nothing is lost or repeated.
// Reset clears all valid bits and the registers.
module sinusoid_trajectory_generator
    import stg_pkg::*;
#(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // time_stamp
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata    // position, velocity, acceleration
);

    logic signed [31:0] offset_reg, amp_reg;
    logic        [23:0] freq_reg;
    logic        [15:0] phase_reg;
    logic en;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            amp_reg    <= '0;
            freq_reg   <= '0;
            phase_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OFFSET:    offset_reg <= cfg_data;
                REG_AMPLITUDE: amp_reg    <= cfg_data;
                REG_FREQUENCY: freq_reg   <= cfg_data[23:0];
                REG_PHASE:     phase_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // angle stage: f*t + phase, quantize, quadrant fold
    localparam logic [31:0] ANG_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
    logic [31:0] ang;
    logic signed [31:0] ang_s, red;
    logic fold;
    always_comb
    begin
        ang   = (32'(56'(freq_reg) * 56'(s_axis_tdata)) + {phase_reg, 16'd0}) & ANG_MASK;
        ang_s = signed'(ang);
        fold  = 1'b0;
        red   = ang_s;
        if (ang_s > 32'sh40000000)
        begin
            red  = ang_s - 32'sh7FFFFFFF - 32'sd1;
            fold = 1'b1;
        end
        else if (ang_s < -32'sh40000000)
        begin
            red  = ang_s + 32'sh7FFFFFFF + 32'sd1;
            fold = 1'b1;
        end
    end

    logic               a_valid_reg;
    logic signed [31:0] a_ang_reg;
    side_t              a_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ang_reg  <= red;
            a_side_reg <= '{off: offset_reg, amp: amp_reg, freq: freq_reg, neg: fold};
        end
    end

    logic               c_valid;
    logic signed [33:0] c_cos, c_sin;
    side_t              c_side;
    logic [47:0] pos, vel, acc;

    stg_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (a_valid_reg),
        .in_angle  (a_ang_reg),
        .in_side   (a_side_reg),
        .out_valid (c_valid),
        .out_cos   (c_cos),
        .out_sin   (c_sin),
        .out_side  (c_side)
    );

    stg_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_valid),
        .in_cos    (c_cos),
        .in_sin    (c_sin),
        .in_side   (c_side),
        .out_valid (m_axis_tvalid),
        .out_pos   (pos),
        .out_vel   (vel),
        .out_acc   (acc)
    );

    assign m_axis_tdata = {acc, vel, pos};

endmodule

/* test/tb_sinusoid_trajectory_generator.sv */
// Testbench for the sinusoid trajectory generator: drives time stamps under
// several register settings and checks position, velocity and acceleration
// against a bit-exact predictor. Depends on stg_pkg and the top-level RTL.
module tb_sinusoid_trajectory_generator;
    import stg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANG_BITS = 16;
    localparam int STAGES = 16;
    localparam int LATENCY = STAGES + 7;
    localparam longint OUT_HI = 64'sd140737488355327;
    localparam longint OUT_LO = -64'sd140737488355328;

    typedef struct packed {
        logic [47:0] acc;
        logic [47:0] vel;
        logic [47:0] pos;
    } motion_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;   // time_stamp
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [143:0] m_axis_tdata;   // position, velocity, acceleration

    // predictor copy of the registers
    logic signed [31:0] offset_reg;
    logic signed [31:0] amp_reg;
    logic [23:0]        freq_reg;
    logic [15:0]        phase_reg;

    logic [31:0] stamp_q[$];
    motion_t     motion_q[$];
    int          mismatches;
    int          accepted;
    int          burst_left;
    int          gap_left;
    int          hold_left;
    int          stall_phase;
    bit          long_hold_req;

    sinusoid_trajectory_generator #(.ANGLE_BITS(ANG_BITS), .CORDIC_STAGES(STAGES)) DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [47:0] clamp48(longint v);
        if (v > OUT_HI)
            v = OUT_HI;
        if (v < OUT_LO)
            v = OUT_LO;
        return v[47:0];
    endfunction

    // expected motion for one time stamp under the current registers
    function automatic motion_t predict_motion(logic [31:0] stamp);
        logic [63:0] prod;
        logic [31:0] angle;
        longint z, x, y, nx, ny, s, c, a_sin, a_cos, w, w2, vel, acc;
        bit flip;
        motion_t m;
        prod = 64'(freq_reg) * 64'(stamp);
        angle = prod[31:0] + {phase_reg, 16'h0};
        angle = angle & ~((32'd1 << (32 - ANG_BITS)) - 32'd1);
        z = longint'(signed'(angle));
        flip = 1'b0;
        if (z > (64'sd1 <<< 30))
        begin
            z = z - (64'sd1 <<< 31);
            flip = 1'b1;
        end
        else if (z < -(64'sd1 <<< 30))
        begin
            z = z + (64'sd1 <<< 31);
            flip = 1'b1;
        end
        x = longint'(GAIN_Q30);
        y = 0;
        for (int i = 0; i < STAGES && i < TBL_LEN; i++)
        begin
            if (z >= 0)
            begin
                nx = x - floor_shift(y, i);
                ny = y + floor_shift(x, i);
                z = z - longint'(atan_turns(5'(i)));
            end
            else
            begin
                nx = x + floor_shift(y, i);
                ny = y - floor_shift(x, i);
                z = z + longint'(atan_turns(5'(i)));
            end
            x = nx;
            y = ny;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
        a_sin = floor_shift(longint'(amp_reg) * s + (64'sd1 <<< 29), 30);
        a_cos = floor_shift(longint'(amp_reg) * c + (64'sd1 <<< 29), 30);
        w = longint'((64'(freq_reg) * 64'(TWOPI_Q29) + (64'd1 << 28)) >> 29);
        w2 = longint'((64'(w) * 64'(w) + (64'd1 << 15)) >> 16);
        vel = floor_shift(w * a_cos + (64'sd1 <<< 15), 16);
        acc = -((w2 >>> 16) * a_sin
                + floor_shift((w2 & 64'hFFFF) * a_sin + (64'sd1 <<< 15), 16));
        m.pos = clamp48(longint'(offset_reg) + a_sin);
        m.vel = clamp48(vel);
        m.acc = clamp48(acc);
        return m;
    endfunction

    // register write, block idle, predictor updated alongside
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_OFFSET:    offset_reg = val;
            REG_AMPLITUDE: amp_reg = val;
            REG_FREQUENCY: freq_reg = val[23:0];
            REG_PHASE:     phase_reg = val[15:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [31:0] off, logic [31:0] amp, logic [31:0] fr,
                             logic [31:0] ph);
        write_reg(REG_OFFSET, off);
        write_reg(REG_AMPLITUDE, amp);
        write_reg(REG_FREQUENCY, fr);
        write_reg(REG_PHASE, ph);
    endtask

    // wait for the pipeline to drain before touching registers
    task automatic drain();
        while (stamp_q.size() != 0 || s_axis_tvalid || motion_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic push_random(int n);
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(0, 4))
                0: stamp_q.push_back($urandom_range(0, 255) << 16);
                1: stamp_q.push_back($urandom_range(0, 65535));
                default: stamp_q.push_back($urandom);
            endcase
        end
    endtask

    // driver: bursts and gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            logic fire;
            logic busy;
            fire = s_axis_tvalid && s_axis_tready;
            busy = s_axis_tvalid && !fire;
            if (fire)
            begin
                motion_q.push_back(predict_motion(s_axis_tdata));
                void'(stamp_q.pop_front());
            end
            if (!busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (stamp_q.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= stamp_q[0];
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall pattern and result checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            mismatches <= 0;
            accepted <= 0;
            hold_left <= 0;
            stall_phase <= 0;
        end
        else
        begin
            motion_t got;
            motion_t want;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                accepted <= accepted + 1;
                if (motion_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result %h", m_axis_tdata);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = motion_q.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                            $display("mismatch pos %h/%h vel %h/%h acc %h/%h (exp/act)",
                                     want.pos, got.pos, want.vel, got.vel,
                                     want.acc, got.acc);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            stall_phase <= stall_phase + 1;
            if (long_hold_req && hold_left == 0)
            begin
                hold_left <= 200;
                m_axis_tready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_axis_tready <= (hold_left == 1);
            end
            else if (stall_phase[8])
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 3) != 0) && (stall_phase % 7 != 3);
        end
    end

    initial
    begin
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        long_hold_req = 1'b0;
        offset_reg = '0;
        amp_reg = '0;
        freq_reg = '0;
        phase_reg = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: all outputs from zero registers
        stamp_q.push_back(32'h0);
        stamp_q.push_back(32'hFFFF_FFFF);
        drain();

        // directed: quarter-turn boundaries, extremes of amplitude and offset
        write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0);
        stamp_q.push_back(32'h0000_0000);
        stamp_q.push_back(32'h0000_4000);
        stamp_q.push_back(32'h0000_4001);
        stamp_q.push_back(32'h0000_8000);
        stamp_q.push_back(32'h0000_C000);
        stamp_q.push_back(32'h0000_BFFF);
        stamp_q.push_back(32'h0000_C001);
        stamp_q.push_back(32'hFFFF_FFFF);
        stamp_q.push_back(32'h8000_0000);
        drain();
        // largest frequency: acceleration saturates
        write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h00FF_FFFF, 32'hFFFF);
        stamp_q.push_back(32'h0000_0001);
        stamp_q.push_back(32'h1234_5678);
        stamp_q.push_back(32'hFFFF_FFFF);
        stamp_q.push_back(32'h0000_3FFF);
        drain();
        // zero amplitude, phase at a quarter turn
        write_all(32'h0001_0000, 32'h0, 32'h0010_0000, 32'h4000);
        stamp_q.push_back(32'h0000_8000);
        stamp_q.push_back(32'hAAAA_5555);
        drain();
        // index past the list cannot be formed on a 2-bit index; none tested

        // random phases, each with its own register setting
        for (int ph = 0; ph < 6; ph++)
        begin
            write_all($urandom, $urandom,
                      (ph % 2) ? $urandom_range(0, 32'hFF_FFFF) : $urandom_range(0, 32'h3_0000),
                      $urandom_range(0, 65535));
            if (ph == 2)
            begin
                push_random(40);
                // hold the request until the receiver has started its long stall
                long_hold_req = 1'b1;
                wait (hold_left != 0);
                long_hold_req = 1'b0;
                push_random(60);
            end
            else
                push_random(100);
            drain();
        end

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
